FILE: rtl/cached_rtc_local_time_display_assert.svh
// assertion macros for the cached rtc local time display rtl
// used by files that take this header through an include
`ifndef CACHED_RTC_LOCAL_TIME_DISPLAY_ASSERT_SVH
`define CACHED_RTC_LOCAL_TIME_DISPLAY_ASSERT_SVH

// implication checked on every rising clock edge, off while reset is low
`define CRTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define CRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/crtc_pkg.sv
// shared types and constants for the cached rtc local time display
// no dependencies
package crtc_pkg;

  localparam int unsigned OffsetClamp = 104;
  localparam int unsigned OffsetBias  = 48;
  localparam int unsigned DayMinutes  = 1440;
  localparam int unsigned HourMinutes = 60;
  localparam int unsigned QuarterMin  = 15;
  localparam int unsigned HalfDayHrs  = 12;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_SET   = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RTC_PRESENT  = 2'd0,
    CFG_UTC_OFFSET   = 2'd1,
    CFG_TWELVE_HOUR  = 2'd2,
    CFG_POLL_INTERVAL = 2'd3
  } cfg_idx_e;

  // utc time picked for one word, handed to the local time converter
  typedef struct packed {
    logic       ok;
    logic       show;     // fields carry a time
    logic [4:0] hour;
    logic [5:0] minute;
    logic       taken;
  } utc_t;

  // converted word, as it goes to the result register
  typedef struct packed {
    logic       ok;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       pm;
    logic       taken;
  } disp_t;

endpackage

FILE: rtl/cached_rtc_local_time_display.sv
// top level of the cached rtc local time display
// depends on crtc_pkg, crtc_local and cached_rtc_local_time_display_assert.svh

// One word in, one word out, one word per clock sustained while the result is not
// stalled. A query word decides at acceptance whether to poll (the millisecond
// gap since the last poll against poll_interval_ms) and updates the cache and poll
// time at that same edge, so the next word, even in the following cycle, sees the
// new state. The chosen utc time sits in a stage register; the converter then adds
// the clamped quarter-hour offset, wraps to one day, splits hours by a reciprocal
// multiply and loads the result register once it is free. out_valid_o rises when
// the word moves from the stage register into the result register. A stalled
// result does not block input until the stage register is full too. Set words
// load the cache and force the next query to poll; a failed write changes nothing.
// Configuration writes are always ready and take effect at the next edge.
module cached_rtc_local_time_display (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [crtc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         op_i,
  input  logic [31:0]                  now_ms_i,
  input  logic                         rtc_ok_i,
  input  logic [4:0]                   rtc_hour_i,
  input  logic [5:0]                   rtc_minute_i,
  input  logic [4:0]                   set_hour_i,
  input  logic [5:0]                   set_minute_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ok_o,
  output logic [4:0]                   show_hour_o,
  output logic [5:0]                   show_minute_o,
  output logic                         pm_o,
  output logic                         reading_taken_o
);
  import crtc_pkg::*;

  `include "cached_rtc_local_time_display_assert.svh"

  // configuration registers
  logic        rtc_present_q;
  logic [7:0]  utc_offset_q;
  logic        twelve_hour_q;
  logic [31:0] poll_interval_q;

  // cache state
  logic [31:0] last_poll_q, last_poll_d;
  logic [4:0]  cached_hour_q, cached_hour_d;
  logic [5:0]  cached_minute_q, cached_minute_d;
  logic        cache_valid_q, cache_valid_d;

  // pipeline
  logic  stage_valid_q;
  utc_t  stage_q, stage_d;
  disp_t disp;
  disp_t out_q;
  logic  out_valid_q;

  logic in_accept;
  logic out_take;     // result register can load
  logic within_interval;
  logic [31:0] since_poll;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtc_present_q   <= 1'b0;
      utc_offset_q    <= 8'(OffsetBias);
      twelve_hour_q   <= 1'b0;
      poll_interval_q <= 32'd1000;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RTC_PRESENT:   rtc_present_q   <= cfg_data_i[0];
        CFG_UTC_OFFSET:    utc_offset_q    <= cfg_data_i[7:0];
        CFG_TWELVE_HOUR:   twelve_hour_q   <= cfg_data_i[0];
        CFG_POLL_INTERVAL: poll_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: result register frees when empty or taken, stage frees into it
  assign out_take   = !out_valid_q || !out_stall_i;
  assign in_stall_o = stage_valid_q && !out_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  // poll decision, wrapping millisecond difference
  assign since_poll      = now_ms_i - last_poll_q;
  assign within_interval = (last_poll_q != 32'd0) && (since_poll < poll_interval_q);

  always_comb begin
    last_poll_d     = last_poll_q;
    cached_hour_d   = cached_hour_q;
    cached_minute_d = cached_minute_q;
    cache_valid_d   = cache_valid_q;
    stage_d         = '0;
    if (op_i == OP_SET) begin
      stage_d.ok = rtc_ok_i;
      if (rtc_ok_i) begin
        // zero poll time forces the next query to read the rtc
        last_poll_d     = '0;
        cached_hour_d   = set_hour_i;
        cached_minute_d = set_minute_i;
        cache_valid_d   = 1'b1;
      end
    end else if (rtc_present_q) begin
      if (within_interval) begin
        stage_d.ok = 1'b1;
      end else if (rtc_ok_i) begin
        cached_hour_d   = rtc_hour_i;
        cached_minute_d = rtc_minute_i;
        last_poll_d     = now_ms_i;
        cache_valid_d   = 1'b1;
        stage_d.ok      = 1'b1;
        stage_d.taken   = 1'b1;
      end else if (cache_valid_q) begin
        // failed read falls back to the cache
        last_poll_d = now_ms_i;
        stage_d.ok  = 1'b1;
      end
      stage_d.show   = stage_d.ok;
      stage_d.hour   = cached_hour_d;
      stage_d.minute = cached_minute_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q     <= '0;
      cached_hour_q   <= '0;
      cached_minute_q <= '0;
      cache_valid_q   <= 1'b0;
    end else if (in_accept) begin
      last_poll_q     <= last_poll_d;
      cached_hour_q   <= cached_hour_d;
      cached_minute_q <= cached_minute_d;
      cache_valid_q   <= cache_valid_d;
    end
  end

  // stage and result registers, valid part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        stage_valid_q <= 1'b1;
      end else if (out_take) begin
        stage_valid_q <= 1'b0;
      end
      if (out_take) begin
        out_valid_q <= stage_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_q <= stage_d;
    end
    if (out_take && stage_valid_q) begin
      out_q <= disp;
    end
  end

  crtc_local u_local (
    .utc_i               (stage_q),
    .utc_offset_biased_i (utc_offset_q),
    .twelve_hour_mode_i  (twelve_hour_q),
    .disp_o              (disp)
  );

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_q.ok;
  assign show_hour_o     = out_q.hour;
  assign show_minute_o   = out_q.minute;
  assign pm_o            = out_q.pm;
  assign reading_taken_o = out_q.taken;

  `CRTC_ASSERT_IMPLY(a_fail_zero, clk_i, rst_ni, out_valid_o && !ok_o,
    show_hour_o == 5'd0 && show_minute_o == 6'd0 && !pm_o && !reading_taken_o,
    "failed word carries nonzero fields")
  `CRTC_ASSERT_IMPLY(a_taken_ok, clk_i, rst_ni, out_valid_o && reading_taken_o, ok_o,
    "reading taken on a failed word")
  `CRTC_ASSERT_IMPLY(a_time_range, clk_i, rst_ni, out_valid_o,
    show_minute_o < 6'd60 && show_hour_o < 5'd24, "local time out of range")
  `CRTC_ASSERT_NEXT(a_set_forces_poll, clk_i, rst_ni,
    in_accept && op_i == OP_SET && rtc_ok_i, last_poll_q == 32'd0 && cache_valid_q,
    "successful set did not clear poll time")

endmodule

FILE: rtl/crtc_local.sv
// utc to local time converter: offset add, day wrap, hour split, 12-hour form
// depends on crtc_pkg
module crtc_local (
  input  crtc_pkg::utc_t  utc_i,
  input  logic [7:0]      utc_offset_biased_i,
  input  logic            twelve_hour_mode_i,
  output crtc_pkg::disp_t disp_o
);
  import crtc_pkg::*;

  localparam logic [12:0] DayW     = 13'(DayMinutes);
  localparam logic [12:0] TwoDayW  = 13'(2 * DayMinutes);
  localparam logic [12:0] BiasAdj  = 13'(DayMinutes - OffsetBias * QuarterMin);
  localparam logic [10:0] Recip60  = 11'((65536 + HourMinutes - 1) / HourMinutes);
  localparam logic [4:0]  HalfDay  = 5'(HalfDayHrs);

  logic [7:0]  off;
  logic [10:0] off15;
  logic [12:0] total;
  logic [10:0] wrapped;
  logic [21:0] prod;
  logic [4:0]  h24;
  logic [10:0] h_min;
  logic [5:0]  minute;
  logic        pm;
  logic [4:0]  h12;

  always_comb begin
    off   = (utc_offset_biased_i > 8'(OffsetClamp)) ? 8'(OffsetClamp) : utc_offset_biased_i;
    off15 = 11'(off) * 11'(QuarterMin);
    total = 13'(utc_i.hour) * 13'(HourMinutes) + 13'(utc_i.minute) + 13'(off15) + BiasAdj;
    if (total >= TwoDayW) begin
      wrapped = 11'(total - TwoDayW);
    end else if (total >= DayW) begin
      wrapped = 11'(total - DayW);
    end else begin
      wrapped = 11'(total);
    end
    // divide by 60 through a reciprocal, exact below one day
    prod   = 22'(wrapped) * 22'(Recip60);
    h24    = prod[20:16];
    h_min  = 11'(h24) * 11'(HourMinutes);
    minute = 6'(wrapped - h_min);
    pm     = (h24 >= HalfDay);
    h12    = pm ? h24 - HalfDay : h24;
    if (h12 == 5'd0) begin
      h12 = HalfDay;
    end

    disp_o.ok = utc_i.ok;
    if (utc_i.show) begin
      disp_o.hour   = twelve_hour_mode_i ? h12 : h24;
      disp_o.minute = minute;
      disp_o.pm     = pm;
      disp_o.taken  = utc_i.taken;
    end else begin
      disp_o.hour   = '0;
      disp_o.minute = '0;
      disp_o.pm     = 1'b0;
      disp_o.taken  = 1'b0;
    end
  end

endmodule
